/* hdl/fcw_pkg.sv */
// Package for the FAT16 cluster chain walker: field widths, operation and
// status codes, register indexes and reset values.
// No dependencies; every other file of the block uses it.
package fcw_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 4096;

   localparam int OP_W      = 2;
   localparam int CLUSTER_W = 16;
   localparam int LENGTH_W  = 32;
   localparam int STATUS_W  = 2;
   localparam int ADDR_W    = 40;
   localparam int COUNT_W   = 20;

   localparam int BPS_W     = 13;
   localparam int SPC_W     = 8;
   localparam int DSS_W     = 20;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 20;

   // Operation codes
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_START = 2'd1;
   localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_GIVEN  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_LOADED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_IDLE   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_SECTOR    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTORS_PER_CLUSTER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_START_SECTOR   = 2'd2;

   localparam logic [BPS_W-1:0] BPS_RESET = 13'd512;
   localparam logic [SPC_W-1:0] SPC_RESET = 8'd1;
   localparam logic [DSS_W-1:0] DSS_RESET = 20'd0;

   localparam logic [CLUSTER_W-1:0] END_MARK           = 16'hFFFF;
   localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = 16'd2;
   localparam logic [COUNT_W-1:0]   COUNT_MAX          = 20'hFFFFF;

endpackage

/* hdl/fcw_if.sv */
// Channel interfaces of the FAT16 cluster chain walker: request, response
// and register write channels, each with valid, ready and payload.
// Depends on fcw_pkg.
interface fcw_req_if;
   logic                             valid;
   logic                             ready;
   logic [fcw_pkg::OP_W-1:0]         operation;
   logic [fcw_pkg::CLUSTER_W-1:0]    entry_index;
   logic [fcw_pkg::CLUSTER_W-1:0]    entry_value;
   logic [fcw_pkg::LENGTH_W-1:0]     file_length;

   modport source (output valid, operation, entry_index, entry_value, file_length,
                   input ready);
   modport sink   (input valid, operation, entry_index, entry_value, file_length,
                   output ready);
endinterface

interface fcw_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [fcw_pkg::STATUS_W-1:0]     status;
   logic [fcw_pkg::CLUSTER_W-1:0]    cluster_number;
   logic [fcw_pkg::ADDR_W-1:0]       byte_address;
   logic [fcw_pkg::COUNT_W-1:0]      byte_count;
   logic                             last;

   modport source (output valid, status, cluster_number, byte_address, byte_count, last,
                   input ready);
   modport sink   (input valid, status, cluster_number, byte_address, byte_count, last,
                   output ready);
endinterface

interface fcw_csr_if;
   logic                             valid;
   logic                             ready;
   logic [fcw_pkg::CSR_IDX_W-1:0]    reg_index;
   logic [fcw_pkg::CSR_DATA_W-1:0]   wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* hdl/fat16_cluster_chain_walker.sv */
// FAT16 cluster chain walker: allocation table in a synchronous memory, chain state
// and a response register. Depends on fcw_pkg, fcw_if.sv and fcw_addr_unit.
// A load or a refused request goes from idle straight to emit; a start passes check,
// math and emit, a next fetch, check, math and emit, skipping math when the cluster is
// out of range; emit holds through any output stall. One request is in work at a time.
// Reset is synchronous, active high, clears chain state and registers; table undefined.
module fat16_cluster_chain_walker #(
   parameter int TABLE_ENTRIES = fcw_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   fcw_req_if.sink   req_ch,
   fcw_rsp_if.source rsp_ch,
   fcw_csr_if.sink   csr_ch
);

   localparam int TBL_AW = $clog2(TABLE_ENTRIES);
   localparam logic [fcw_pkg::CLUSTER_W:0] TableLimit = (fcw_pkg::CLUSTER_W+1)'(TABLE_ENTRIES);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FETCH = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_MATH  = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0] state_ff, state_in;

   logic [fcw_pkg::CLUSTER_W-1:0] cur_ff, cur_in;
   logic [fcw_pkg::LENGTH_W-1:0]  left_ff, left_in;
   logic                          active_ff, active_in;

   logic [fcw_pkg::BPS_W-1:0] bps_ff;
   logic [fcw_pkg::SPC_W-1:0] spc_ff;
   logic [fcw_pkg::DSS_W-1:0] dss_ff;

   logic [fcw_pkg::STATUS_W-1:0]  res_status_ff,  res_status_in;
   logic [fcw_pkg::CLUSTER_W-1:0] res_cluster_ff, res_cluster_in;
   logic [fcw_pkg::ADDR_W-1:0]    res_addr_ff,    res_addr_in;
   logic [fcw_pkg::COUNT_W-1:0]   res_count_ff,   res_count_in;
   logic                          res_last_ff,    res_last_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fcw_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [fcw_pkg::CLUSTER_W-1:0] rsp_cluster_ff;
   logic [fcw_pkg::ADDR_W-1:0]    rsp_addr_ff;
   logic [fcw_pkg::COUNT_W-1:0]   rsp_count_ff;
   logic                          rsp_last_ff;

   logic [fcw_pkg::CLUSTER_W-1:0] table_mem [TABLE_ENTRIES];
   logic [fcw_pkg::CLUSTER_W-1:0] rd_data_ff;
   logic                          wr_en;

   logic                          req_fire;
   logic                          out_free;
   logic                          unit_load;
   logic                          idx_in_range;
   logic                          cur_in_range;
   logic                          chain_end;
   logic [fcw_pkg::ADDR_W-1:0]    unit_addr;
   logic [fcw_pkg::COUNT_W-1:0]   unit_csize;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign idx_in_range = ({1'b0, req_ch.entry_index} < TableLimit);
   assign cur_in_range = (cur_ff >= fcw_pkg::FIRST_DATA_CLUSTER) && ({1'b0, cur_ff} < TableLimit);
   assign chain_end    = (rd_data_ff == fcw_pkg::END_MARK) || (rd_data_ff == '0);

   assign wr_en = req_fire && (req_ch.operation == fcw_pkg::OP_LOAD) && idx_in_range;

   // The read address is always the current cluster: in the request cycle of
   // a next it fetches the successor, in the check cycle the look-ahead entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[req_ch.entry_index[TBL_AW-1:0]] <= req_ch.entry_value;
      end
      rd_data_ff <= table_mem[cur_ff[TBL_AW-1:0]];
   end

   fcw_addr_unit u_addr (
      .clock             (clock),
      .load              (unit_load),
      .cluster           (cur_ff),
      .sector_count      (spc_ff),
      .sector_bytes      (bps_ff),
      .data_start_sector (dss_ff),
      .byte_address      (unit_addr),
      .cluster_size      (unit_csize)
   );

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      left_in        = left_ff;
      active_in      = active_ff;
      res_status_in  = res_status_ff;
      res_cluster_in = res_cluster_ff;
      res_addr_in    = res_addr_ff;
      res_count_in   = res_count_ff;
      res_last_in    = res_last_ff;
      unit_load      = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_cluster_in = '0;
               res_addr_in    = '0;
               res_count_in   = '0;
               res_last_in    = 1'b0;
               res_status_in  = fcw_pkg::ST_IDLE;
               state_in       = S_EMIT;
               case (req_ch.operation)
                  fcw_pkg::OP_LOAD: begin
                     if (idx_in_range) begin
                        res_status_in = fcw_pkg::ST_LOADED;
                     end else begin
                        res_status_in  = fcw_pkg::ST_RANGE;
                        res_cluster_in = req_ch.entry_index;
                     end
                  end
                  fcw_pkg::OP_START: begin
                     cur_in    = req_ch.entry_index;
                     left_in   = req_ch.file_length;
                     active_in = 1'b1;
                     state_in  = S_CHECK;
                  end
                  fcw_pkg::OP_NEXT: begin
                     if (active_ff) begin
                        state_in = S_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FETCH: begin
            cur_in   = rd_data_ff;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (cur_in_range) begin
               unit_load = 1'b1;
               state_in  = S_MATH;
            end else begin
               active_in      = 1'b0;
               res_status_in  = fcw_pkg::ST_RANGE;
               res_cluster_in = cur_ff;
               state_in       = S_EMIT;
            end
         end
         S_MATH: begin
            res_status_in  = fcw_pkg::ST_GIVEN;
            res_cluster_in = cur_ff;
            res_addr_in    = unit_addr;
            res_last_in    = chain_end;
            // A partial cluster uses up the rest of the file.
            if (left_ff < fcw_pkg::LENGTH_W'(unit_csize)) begin
               res_count_in = left_ff[fcw_pkg::COUNT_W-1:0];
               left_in      = '0;
            end else begin
               res_count_in = unit_csize;
               left_in      = left_ff - fcw_pkg::LENGTH_W'(unit_csize);
            end
            if (chain_end) begin
               active_in = 1'b0;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         left_ff      <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         left_ff      <= left_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff  <= res_status_in;
      res_cluster_ff <= res_cluster_in;
      res_addr_ff    <= res_addr_in;
      res_count_ff   <= res_count_in;
      res_last_ff    <= res_last_in;
      if ((state_ff == S_EMIT) && out_free) begin
         rsp_status_ff  <= res_status_ff;
         rsp_cluster_ff <= res_cluster_ff;
         rsp_addr_ff    <= res_addr_ff;
         rsp_count_ff   <= res_count_ff;
         rsp_last_ff    <= res_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff <= fcw_pkg::BPS_RESET;
         spc_ff <= fcw_pkg::SPC_RESET;
         dss_ff <= fcw_pkg::DSS_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.reg_index)
            fcw_pkg::CSR_BYTES_PER_SECTOR:    bps_ff <= csr_ch.wdata[fcw_pkg::BPS_W-1:0];
            fcw_pkg::CSR_SECTORS_PER_CLUSTER: spc_ff <= csr_ch.wdata[fcw_pkg::SPC_W-1:0];
            fcw_pkg::CSR_DATA_START_SECTOR:   dss_ff <= csr_ch.wdata[fcw_pkg::DSS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.cluster_number = rsp_cluster_ff;
   assign rsp_ch.byte_address   = rsp_addr_ff;
   assign rsp_ch.byte_count     = rsp_count_ff;
   assign rsp_ch.last           = rsp_last_ff;

endmodule

/* hdl/fcw_addr_unit.sv */
// Two-step address arithmetic for one delivered cluster: the first multiply
// is registered, the sum and the second multiply follow in the next cycle.
// Depends on fcw_pkg.
module fcw_addr_unit (
   input  logic                            clock,
   input  logic                            load,
   input  logic [fcw_pkg::CLUSTER_W-1:0]   cluster,
   input  logic [fcw_pkg::SPC_W-1:0]       sector_count,
   input  logic [fcw_pkg::BPS_W-1:0]       sector_bytes,
   input  logic [fcw_pkg::DSS_W-1:0]       data_start_sector,
   output logic [fcw_pkg::ADDR_W-1:0]      byte_address,
   output logic [fcw_pkg::COUNT_W-1:0]     cluster_size
);

   localparam int PROD_W  = fcw_pkg::CLUSTER_W + fcw_pkg::SPC_W;
   localparam int BASE_W  = PROD_W + 1;
   localparam int CSIZE_W = fcw_pkg::SPC_W + fcw_pkg::BPS_W;
   localparam int RAW_W   = BASE_W + fcw_pkg::BPS_W;

   logic [PROD_W-1:0]  prod_ff,  prod_in;
   logic [CSIZE_W-1:0] csize_ff, csize_in;
   logic [BASE_W-1:0]  base;
   logic [RAW_W-1:0]   addr_raw;

   assign prod_in  = PROD_W'(cluster - fcw_pkg::FIRST_DATA_CLUSTER) * PROD_W'(sector_count);
   assign csize_in = CSIZE_W'(sector_count) * CSIZE_W'(sector_bytes);

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff  <= prod_in;
         csize_ff <= csize_in;
      end
   end

   assign base     = BASE_W'(prod_ff) + BASE_W'(data_start_sector);
   assign addr_raw = RAW_W'(base) * RAW_W'(sector_bytes);

   assign byte_address = fcw_pkg::ADDR_W'(addr_raw);
   // Clusters larger than the count field can show are clipped to its maximum.
   assign cluster_size = (csize_ff > CSIZE_W'(fcw_pkg::COUNT_MAX)) ? fcw_pkg::COUNT_MAX
                                                                   : csize_ff[fcw_pkg::COUNT_W-1:0];

endmodule

/* hdl/fcw_checker.sv */
// Port-level checks for the FAT16 cluster chain walker, attached to the top
// level by the bind statement at the end of this file.
// Depends on fcw_pkg and fat16_cluster_chain_walker.
module fcw_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [fcw_pkg::STATUS_W-1:0]    rsp_status,
   input logic [fcw_pkg::CLUSTER_W-1:0]   rsp_cluster_number,
   input logic [fcw_pkg::ADDR_W-1:0]      rsp_byte_address,
   input logic [fcw_pkg::COUNT_W-1:0]     rsp_byte_count,
   input logic                            rsp_last
);

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_cluster_number)
         && $stable(rsp_byte_address) && $stable(rsp_byte_count) && $stable(rsp_last))
      else $error("response payload changed while stalled");

   // One transaction at a time: the request side closes after each one.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   // Only a delivered cluster carries an address, a count or a last mark.
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != fcw_pkg::ST_GIVEN) |->
         (rsp_byte_address == '0) && (rsp_byte_count == '0) && !rsp_last)
      else $error("non-delivery response carries cluster data");

endmodule

bind fat16_cluster_chain_walker fcw_checker u_fcw_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_cluster_number (rsp_ch.cluster_number),
   .rsp_byte_address   (rsp_ch.byte_address),
   .rsp_byte_count     (rsp_ch.byte_count),
   .rsp_last           (rsp_ch.last)
);

/* tb/tb_fat16_cluster_chain_walker.sv */
// Self-checking testbench for the FAT16 cluster chain walker: a directed table, then
// random chains and stray requests over several sector and cluster geometries.
// Depends on fcw_pkg, the channel interfaces in fcw_if.sv and the walker RTL.
`timescale 1ns / 1ps

module tb_fat16_cluster_chain_walker;

   localparam int FAT_ENTRIES = fcw_pkg::TABLE_ENTRIES_DEFAULT;
   localparam int FAT_AW      = $clog2(FAT_ENTRIES);
   localparam logic [fcw_pkg::OP_W-1:0]      OP_UNUSED  = 2'd3;
   localparam logic [fcw_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 334;
   localparam int DIRECTED_ROWS = 26;

   typedef struct packed {
      logic [fcw_pkg::STATUS_W-1:0]  status;
      logic [fcw_pkg::CLUSTER_W-1:0] cluster_number;
      logic [fcw_pkg::ADDR_W-1:0]    byte_address;
      logic [fcw_pkg::COUNT_W-1:0]   byte_count;
      logic                          last;
   } cluster_rsp_type;

   typedef struct packed {
      logic [fcw_pkg::OP_W-1:0]      op;
      logic [fcw_pkg::CLUSTER_W-1:0] idx;
      logic [fcw_pkg::CLUSTER_W-1:0] val;
      logic [fcw_pkg::LENGTH_W-1:0]  len;
      logic                          typed;
      cluster_rsp_type               exp;
   } walk_row_type;

   localparam cluster_rsp_type RSP_NONE   = '0;
   localparam cluster_rsp_type RSP_IDLE   = '{fcw_pkg::ST_IDLE, 16'd0, 40'd0, 20'd0, 1'b0};
   localparam cluster_rsp_type RSP_LOADED = '{fcw_pkg::ST_LOADED, 16'd0, 40'd0, 20'd0, 1'b0};

   // Values that can be read off at a glance are typed in; the rest use the predictor.
   walk_row_type directed_rows [DIRECTED_ROWS] = '{
      '{fcw_pkg::OP_NEXT,  16'h0000, 16'h0000, 32'h0,         1'b1, RSP_IDLE},
      '{OP_UNUSED,         16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, RSP_IDLE},
      '{fcw_pkg::OP_LOAD,  16'hFFFF, 16'h1234, 32'h0, 1'b1,
        '{fcw_pkg::ST_RANGE, 16'hFFFF, 40'd0, 20'd0, 1'b0}},
      '{fcw_pkg::OP_LOAD,  16'd4096, 16'hFFFF, 32'h0, 1'b1,
        '{fcw_pkg::ST_RANGE, 16'd4096, 40'd0, 20'd0, 1'b0}},
      '{fcw_pkg::OP_LOAD,  16'd0,    16'hFFFF, 32'h0,         1'b1, RSP_LOADED},
      '{fcw_pkg::OP_LOAD,  16'd2,    16'd3,    32'h0,         1'b1, RSP_LOADED},
      '{fcw_pkg::OP_LOAD,  16'd3,    16'd4095, 32'h0,         1'b1, RSP_LOADED},
      '{fcw_pkg::OP_LOAD,  16'd4095, 16'hFFFF, 32'h0,         1'b1, RSP_LOADED},
      '{fcw_pkg::OP_START, 16'd2,    16'h5A5A, 32'd1300,      1'b0, RSP_NONE},
      '{fcw_pkg::OP_NEXT,  16'h0000, 16'h0000, 32'h0,         1'b0, RSP_NONE},
      '{fcw_pkg::OP_NEXT,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, RSP_NONE},
      '{fcw_pkg::OP_NEXT,  16'h0000, 16'h0000, 32'h0,         1'b1, RSP_IDLE},
      '{fcw_pkg::OP_START, 16'd0,    16'h0000, 32'd1000, 1'b1,
        '{fcw_pkg::ST_RANGE, 16'd0, 40'd0, 20'd0, 1'b0}},
      '{fcw_pkg::OP_START, 16'd1,    16'h0000, 32'd1000, 1'b1,
        '{fcw_pkg::ST_RANGE, 16'd1, 40'd0, 20'd0, 1'b0}},
      '{fcw_pkg::OP_START, 16'd4096, 16'h0000, 32'd1000, 1'b1,
        '{fcw_pkg::ST_RANGE, 16'd4096, 40'd0, 20'd0, 1'b0}},
      '{fcw_pkg::OP_START, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
        '{fcw_pkg::ST_RANGE, 16'hFFFF, 40'd0, 20'd0, 1'b0}},
      '{fcw_pkg::OP_NEXT,  16'h0000, 16'h0000, 32'h0,         1'b1, RSP_IDLE},
      '{fcw_pkg::OP_LOAD,  16'd5,    16'd0,    32'h0,         1'b1, RSP_LOADED},
      '{fcw_pkg::OP_START, 16'd5,    16'h0000, 32'd0,         1'b0, RSP_NONE},
      '{fcw_pkg::OP_LOAD,  16'd6,    16'd1,    32'h0,         1'b1, RSP_LOADED},
      '{fcw_pkg::OP_START, 16'd6,    16'h0000, 32'hFFFF_FFFF, 1'b0, RSP_NONE},
      '{fcw_pkg::OP_NEXT,  16'h0000, 16'h0000, 32'h0, 1'b1,
        '{fcw_pkg::ST_RANGE, 16'd1, 40'd0, 20'd0, 1'b0}},
      '{fcw_pkg::OP_LOAD,  16'd7,    16'd7,    32'h0,         1'b1, RSP_LOADED},
      '{fcw_pkg::OP_START, 16'd7,    16'h0000, 32'd100,       1'b0, RSP_NONE},
      '{fcw_pkg::OP_NEXT,  16'h0000, 16'h0000, 32'h0,         1'b0, RSP_NONE},
      '{fcw_pkg::OP_START, 16'd2,    16'h0000, 32'd5,         1'b0, RSP_NONE}
   };

   logic clock;
   logic reset;

   fcw_req_if req_bus ();
   fcw_rsp_if rsp_bus ();
   fcw_csr_if csr_bus ();

   fat16_cluster_chain_walker #(
      .TABLE_ENTRIES(FAT_ENTRIES)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus),
      .csr_ch(csr_bus)
   );

   // Shadow state of the walker.
   logic [fcw_pkg::CLUSTER_W-1:0] fat_copy [FAT_ENTRIES];
   logic                          fat_written [FAT_ENTRIES];
   logic [fcw_pkg::CLUSTER_W-1:0] walk_cluster;
   logic [fcw_pkg::LENGTH_W-1:0]  walk_remaining;
   logic                          walk_active;
   logic [fcw_pkg::BPS_W-1:0]     cfg_bps;
   logic [fcw_pkg::SPC_W-1:0]     cfg_spc;
   logic [fcw_pkg::DSS_W-1:0]     cfg_dss;

   cluster_rsp_type awaited_responses [$];
   int mismatch_count;
   int items_sent;
   int tx_idle_pct;
   int rx_idle_pct;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #10_000_000;
      $display("fat16_cluster_chain_walker regression: fail");
      $finish;
   end

   // Hands out the current cluster and looks ahead at its successor.
   function automatic cluster_rsp_type emit_cluster();
      cluster_rsp_type r;
      logic [63:0] addr;
      logic [63:0] csize;
      logic [63:0] cnt;
      logic [fcw_pkg::CLUSTER_W-1:0] succ;
      r = '0;
      if (walk_cluster < fcw_pkg::FIRST_DATA_CLUSTER || walk_cluster >= FAT_ENTRIES) begin
         walk_active = 1'b0;
         r.status = fcw_pkg::ST_RANGE;
         r.cluster_number = walk_cluster;
         return r;
      end
      addr = ((64'(walk_cluster) - 64'(fcw_pkg::FIRST_DATA_CLUSTER)) * 64'(cfg_spc)
              + 64'(cfg_dss)) * 64'(cfg_bps);
      csize = 64'(cfg_spc) * 64'(cfg_bps);
      if (csize > 64'(fcw_pkg::COUNT_MAX))
         csize = 64'(fcw_pkg::COUNT_MAX);
      cnt = (64'(walk_remaining) < csize) ? 64'(walk_remaining) : csize;
      walk_remaining = walk_remaining - cnt[fcw_pkg::LENGTH_W-1:0];
      // A partial cluster finishes the file data.
      if (cnt < csize)
         walk_remaining = '0;
      succ = fat_copy[walk_cluster[FAT_AW-1:0]];
      r.status = fcw_pkg::ST_GIVEN;
      r.cluster_number = walk_cluster;
      r.byte_address = addr[fcw_pkg::ADDR_W-1:0];
      r.byte_count = cnt[fcw_pkg::COUNT_W-1:0];
      r.last = (succ == fcw_pkg::END_MARK || succ == '0);
      if (r.last)
         walk_active = 1'b0;
      return r;
   endfunction

   function automatic cluster_rsp_type compute_walk_response(
         logic [fcw_pkg::OP_W-1:0] op,
         logic [fcw_pkg::CLUSTER_W-1:0] idx,
         logic [fcw_pkg::CLUSTER_W-1:0] val,
         logic [fcw_pkg::LENGTH_W-1:0] len);
      cluster_rsp_type r;
      r = '0;
      if (op == fcw_pkg::OP_LOAD) begin
         if (idx < FAT_ENTRIES) begin
            fat_copy[idx[FAT_AW-1:0]] = val;
            fat_written[idx[FAT_AW-1:0]] = 1'b1;
            r.status = fcw_pkg::ST_LOADED;
         end else begin
            r.status = fcw_pkg::ST_RANGE;
            r.cluster_number = idx;
         end
      end else if (op == fcw_pkg::OP_START) begin
         walk_cluster = idx;
         walk_remaining = len;
         walk_active = 1'b1;
         r = emit_cluster();
      end else if (op == fcw_pkg::OP_NEXT && walk_active) begin
         walk_cluster = fat_copy[walk_cluster[FAT_AW-1:0]];
         r = emit_cluster();
      end else begin
         r.status = fcw_pkg::ST_IDLE;
      end
      return r;
   endfunction

   // Drives one request transaction and records what it should produce.
   task automatic push_request(logic [fcw_pkg::OP_W-1:0] op,
                               logic [fcw_pkg::CLUSTER_W-1:0] idx,
                               logic [fcw_pkg::CLUSTER_W-1:0] val,
                               logic [fcw_pkg::LENGTH_W-1:0] len,
                               logic typed, cluster_rsp_type exp);
      cluster_rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= op;
      req_bus.entry_index <= idx;
      req_bus.entry_value <= val;
      req_bus.file_length <= len;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = compute_walk_response(op, idx, val, len);
      awaited_responses.insert(awaited_responses.size(), typed ? exp : predicted);
      items_sent++;
   endtask

   function automatic logic [fcw_pkg::CLUSTER_W-1:0] random_link();
      int r;
      r = $urandom_range(0, 9);
      if (r <= 5)
         return fcw_pkg::CLUSTER_W'($urandom_range(fcw_pkg::FIRST_DATA_CLUSTER,
                                                   FAT_ENTRIES - 1));
      else if (r == 6)
         return fcw_pkg::END_MARK;
      else if (r == 7)
         return '0;
      else if (r == 8)
         return 16'd1;
      return fcw_pkg::CLUSTER_W'($urandom_range(0, 16'hFFFF));
   endfunction

   // Loads any table entry the request would read before it has been written, then sends the request.
   task automatic post_request(logic [fcw_pkg::OP_W-1:0] op,
                               logic [fcw_pkg::CLUSTER_W-1:0] idx,
                               logic [fcw_pkg::CLUSTER_W-1:0] val,
                               logic [fcw_pkg::LENGTH_W-1:0] len);
      logic [fcw_pkg::CLUSTER_W-1:0] succ;
      if (op == fcw_pkg::OP_START && idx >= fcw_pkg::FIRST_DATA_CLUSTER && idx < FAT_ENTRIES
          && !fat_written[idx[FAT_AW-1:0]])
         push_request(fcw_pkg::OP_LOAD, idx, random_link(), $urandom, 1'b0, RSP_NONE);
      if (op == fcw_pkg::OP_NEXT && walk_active) begin
         succ = fat_copy[walk_cluster[FAT_AW-1:0]];
         if (succ >= fcw_pkg::FIRST_DATA_CLUSTER && succ < FAT_ENTRIES
             && !fat_written[succ[FAT_AW-1:0]])
            push_request(fcw_pkg::OP_LOAD, succ, random_link(), $urandom, 1'b0, RSP_NONE);
      end
      push_request(op, idx, val, len, 1'b0, RSP_NONE);
   endtask

   task automatic post_stray_request();
      logic [fcw_pkg::CLUSTER_W-1:0] idx;
      if ($urandom_range(0, 1) == 0)
         idx = fcw_pkg::CLUSTER_W'($urandom_range(0, 16'hFFFF));
      else
         idx = fcw_pkg::CLUSTER_W'($urandom_range(0, FAT_ENTRIES - 1));
      post_request(fcw_pkg::OP_W'($urandom_range(0, 3)), idx,
                   fcw_pkg::CLUSTER_W'($urandom_range(0, 16'hFFFF)), $urandom);
   endtask

   // Builds a short chain in the table, starts it and follows it to its end.
   task automatic walk_random_chain();
      logic [fcw_pkg::CLUSTER_W-1:0] links [6];
      logic [fcw_pkg::CLUSTER_W-1:0] tail;
      logic [63:0] csize;
      logic [fcw_pkg::LENGTH_W-1:0] len;
      int hops;
      int steps;
      hops = $urandom_range(1, 6);
      for (int i = 0; i < hops; i++)
         links[i] = fcw_pkg::CLUSTER_W'($urandom_range(fcw_pkg::FIRST_DATA_CLUSTER,
                                                       FAT_ENTRIES - 1));
      for (int i = 0; i + 1 < hops; i++)
         post_request(fcw_pkg::OP_LOAD, links[i], links[i + 1], $urandom);
      case ($urandom_range(0, 3))
         0, 1: tail = fcw_pkg::END_MARK;
         2: tail = '0;
         default: tail = ($urandom_range(0, 1) == 0) ? 16'd1 :
                         fcw_pkg::CLUSTER_W'($urandom_range(FAT_ENTRIES, 16'hFFFF));
      endcase
      post_request(fcw_pkg::OP_LOAD, links[hops - 1], tail, $urandom);
      csize = 64'(cfg_spc) * 64'(cfg_bps);
      if (csize > 64'(fcw_pkg::COUNT_MAX))
         csize = 64'(fcw_pkg::COUNT_MAX);
      case ($urandom_range(0, 3))
         0: len = '0;
         1: len = $urandom;
         2: len = fcw_pkg::LENGTH_W'(csize * 64'(hops));
         default: len = fcw_pkg::LENGTH_W'(csize * 64'($urandom_range(0, hops))
                                           + 64'($urandom_range(1, 1000)));
      endcase
      post_request(fcw_pkg::OP_START, links[0],
                   fcw_pkg::CLUSTER_W'($urandom_range(0, 16'hFFFF)), len);
      steps = hops - 1 + $urandom_range(0, 2);
      for (int i = 0; i < steps; i++) begin
         if ($urandom_range(0, 7) == 0)
            post_stray_request();
         post_request(fcw_pkg::OP_NEXT, fcw_pkg::CLUSTER_W'($urandom_range(0, 16'hFFFF)),
                      fcw_pkg::CLUSTER_W'($urandom_range(0, 16'hFFFF)), $urandom);
      end
   endtask

   task automatic write_register(logic [fcw_pkg::CSR_IDX_W-1:0] idx,
                                 logic [fcw_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wdata     <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         fcw_pkg::CSR_BYTES_PER_SECTOR:    cfg_bps = data[fcw_pkg::BPS_W-1:0];
         fcw_pkg::CSR_SECTORS_PER_CLUSTER: cfg_spc = data[fcw_pkg::SPC_W-1:0];
         fcw_pkg::CSR_DATA_START_SECTOR:   cfg_dss = data[fcw_pkg::DSS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);

   always @(posedge clock) begin
      cluster_rsp_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (awaited_responses.size() == 0) begin
            $error("response transaction with nothing outstanding");
            mismatch_count++;
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
               mismatch_count++;
            end
            if (rsp_bus.cluster_number !== want.cluster_number) begin
               $error("cluster_number: expected %0d, actual %0d",
                      want.cluster_number, rsp_bus.cluster_number);
               mismatch_count++;
            end
            if (rsp_bus.byte_address !== want.byte_address) begin
               $error("byte_address: expected %0d, actual %0d",
                      want.byte_address, rsp_bus.byte_address);
               mismatch_count++;
            end
            if (rsp_bus.byte_count !== want.byte_count) begin
               $error("byte_count: expected %0d, actual %0d",
                      want.byte_count, rsp_bus.byte_count);
               mismatch_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_bus.last);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.operation   = fcw_pkg::OP_LOAD;
      req_bus.entry_index = '0;
      req_bus.entry_value = '0;
      req_bus.file_length = '0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.reg_index   = fcw_pkg::CSR_BYTES_PER_SECTOR;
      csr_bus.wdata       = '0;
      mismatch_count = 0;
      items_sent     = 0;
      tx_idle_pct    = 19;
      rx_idle_pct    = 48;
      for (int i = 0; i < FAT_ENTRIES; i++) begin
         fat_copy[i]    = '0;
         fat_written[i] = 1'b0;
      end
      walk_cluster   = '0;
      walk_remaining = '0;
      walk_active    = 1'b0;
      cfg_bps = fcw_pkg::BPS_RESET;
      cfg_spc = fcw_pkg::SPC_RESET;
      cfg_dss = fcw_pkg::DSS_RESET;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         push_request(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                      directed_rows[i].len, directed_rows[i].typed, directed_rows[i].exp);

      for (int phase = 0; phase < PHASES; phase++) begin
         // Registers only change once every outstanding transaction has drained.
         @(negedge clock);
         req_bus.valid <= 1'b0;
         while (awaited_responses.size() != 0)
            @(negedge clock);
         repeat (8) @(negedge clock);
         if (phase < 2) begin
            tx_idle_pct = 19;
            rx_idle_pct = 48;
         end else if (phase < 4) begin
            tx_idle_pct = 48;
            rx_idle_pct = 19;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         case (phase)
            0: begin
               write_register(fcw_pkg::CSR_BYTES_PER_SECTOR, 20'd4096);
               write_register(fcw_pkg::CSR_SECTORS_PER_CLUSTER, 20'd128);
               write_register(fcw_pkg::CSR_DATA_START_SECTOR, 20'hFFFFF);
            end
            1: begin
               write_register(fcw_pkg::CSR_BYTES_PER_SECTOR, 20'd512);
               write_register(fcw_pkg::CSR_SECTORS_PER_CLUSTER, 20'd1);
               write_register(fcw_pkg::CSR_DATA_START_SECTOR, 20'd0);
            end
            2: begin
               // Cluster size well past the count saturation point.
               write_register(fcw_pkg::CSR_BYTES_PER_SECTOR, 20'h01FFF);
               write_register(fcw_pkg::CSR_SECTORS_PER_CLUSTER, 20'h000FF);
               write_register(fcw_pkg::CSR_DATA_START_SECTOR,
                              fcw_pkg::CSR_DATA_W'($urandom_range(0, 20'hFFFFF)));
            end
            3: begin
               write_register(fcw_pkg::CSR_BYTES_PER_SECTOR, 20'd0);
               write_register(fcw_pkg::CSR_SECTORS_PER_CLUSTER, 20'd0);
               write_register(fcw_pkg::CSR_DATA_START_SECTOR,
                              fcw_pkg::CSR_DATA_W'($urandom_range(0, 20'hFFFFF)));
               write_register(CSR_UNUSED, fcw_pkg::CSR_DATA_W'($urandom_range(0, 20'hFFFFF)));
            end
            4: begin
               write_register(fcw_pkg::CSR_BYTES_PER_SECTOR,
                              fcw_pkg::CSR_DATA_W'($urandom_range(0, 20'hFFFFF)));
               write_register(fcw_pkg::CSR_SECTORS_PER_CLUSTER,
                              fcw_pkg::CSR_DATA_W'($urandom_range(0, 20'hFFFFF)));
               write_register(fcw_pkg::CSR_DATA_START_SECTOR,
                              fcw_pkg::CSR_DATA_W'($urandom_range(0, 20'hFFFFF)));
            end
            default: begin
               write_register(fcw_pkg::CSR_BYTES_PER_SECTOR,
                              fcw_pkg::CSR_DATA_W'($urandom_range(512, 4096)));
               write_register(fcw_pkg::CSR_SECTORS_PER_CLUSTER,
                              fcw_pkg::CSR_DATA_W'($urandom_range(1, 128)));
               write_register(fcw_pkg::CSR_DATA_START_SECTOR,
                              fcw_pkg::CSR_DATA_W'($urandom_range(0, 20'hFFFFF)));
            end
         endcase
         begin
            int quota;
            quota = items_sent + PHASE_ITEMS;
            while (items_sent < quota) begin
               if ($urandom_range(0, 99) < 70)
                  walk_random_chain();
               else
                  post_stray_request();
            end
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (awaited_responses.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && awaited_responses.size() == 0)
         $display("fat16_cluster_chain_walker regression: pass");
      else
         $display("fat16_cluster_chain_walker regression: fail");
      $finish;
   end

endmodule
